[rtl/dmrf_pkg.sv]
package dmrf_pkg;

    // Memory and window sizes
    localparam logic [32:0] VRAM_BYTES    = 33'd16777216;
    localparam logic [12:0] MMIO_BYTES    = 13'd4096;
    localparam logic [15:0] MAX_DIM       = 16'd8192;
    localparam logic [15:0] MIN_DIM       = 16'd64;
    localparam logic [32:0] INIT_AREA_MAX = VRAM_BYTES / 33'd4;

    // Register window: register i at WIN_BASE + 2*i
    localparam logic [11:0] WIN_BASE = 12'h500;
    localparam logic [11:0] WR_END   = 12'h514;
    localparam logic [11:0] RD_END   = 12'h516;

    localparam int NREGS = 10;

    // Register indexes
    localparam logic [3:0] R_ID     = 4'd0;
    localparam logic [3:0] R_XRES   = 4'd1;
    localparam logic [3:0] R_YRES   = 4'd2;
    localparam logic [3:0] R_BPP    = 4'd3;
    localparam logic [3:0] R_ENABLE = 4'd4;
    localparam logic [3:0] R_VWIDTH = 4'd6;
    localparam logic [3:0] R_XOFF   = 4'd8;
    localparam logic [3:0] R_YOFF   = 4'd9;
    localparam logic [3:0] R_VMEM   = 4'd10;
    localparam logic [3:0] R_LAST   = 4'd9;

    // Register values and enable bits
    localparam logic [15:0] ID_CODE    = 16'hb0c5;
    localparam logic [15:0] VMEM_UNITS = 16'(VRAM_BYTES / 33'd65536);
    localparam logic [15:0] BPP_32     = 16'd32;
    localparam logic [15:0] EN_MASK    = 16'h00c3;
    localparam logic [15:0] EN_ON_VAL  = 16'h0001;
    localparam logic [15:0] ALL_ONES   = 16'hffff;
    localparam int          EN_ON      = 0;
    localparam int          EN_CAPS    = 1;
    localparam int          EN_NOCLR   = 7;

    // Initial mode after reset
    localparam logic [13:0] INIT_WIDTH_RST  = 14'd1024;
    localparam logic [13:0] INIT_HEIGHT_RST = 14'd768;

    // Configuration register indexes
    localparam logic CFG_INIT_WIDTH  = 1'b0;
    localparam logic CFG_INIT_HEIGHT = 1'b1;

    // Request commands
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [11:0] byte_offset;
        logic [3:0]  byte_count;
        logic [31:0] write_data;
    } dmrf_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        access_ok;
        logic [13:0] scan_width;
        logic [13:0] scan_height;
        logic [15:0] scan_stride;
        logic [24:0] scan_start;
        logic        clear_vram;
        logic        mode_error;
    } dmrf_rsp_t;

    // Mode register fields used by the geometry check
    typedef struct packed {
        logic [15:0] xres;
        logic [15:0] yres;
        logic [15:0] bpp;
        logic [15:0] enable;
        logic [15:0] vwidth;
        logic [15:0] xoff;
        logic [15:0] yoff;
    } mode_view_t;

    typedef struct packed {
        logic [13:0] width;
        logic [13:0] height;
        logic [15:0] stride;
        logic [24:0] start;
    } geom_t;

    // Initial mode reload: strobe plus the new initial mode
    typedef struct packed {
        logic        load;
        logic [13:0] width;
        logic [13:0] height;
    } init_load_t;

    typedef enum logic [2:0] {
        GEO_IDLE,
        GEO_INIT_MUL,
        GEO_INIT_CHK,
        GEO_PRE,
        GEO_OFFSET,
        GEO_COMMIT
    } geo_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_MUL,
        ST_INIT_CHK,
        ST_READ,
        ST_WMERGE,
        ST_VPRE,
        ST_VOFF,
        ST_VCOMMIT,
        ST_DONE
    } ctrl_state_t;

    function automatic geom_t initial_geom(input logic [13:0] w, input logic [13:0] h);
        geom_t g;
        g.width  = w;
        g.height = h;
        g.stride = {w, 2'b00};
        g.start  = '0;
        return g;
    endfunction

endpackage

[rtl/dmrf_regfile.sv]
module dmrf_regfile
    import dmrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  init_load_t  init,
    input  logic        wr_en,
    input  logic [15:0] wr_val,
    input  logic [3:0]  idx,
    output logic [15:0] rd_raw,
    output logic [15:0] rd_vis,
    output logic        wr_taken,
    output logic        wr_clr,
    output mode_view_t  view
);

    logic [15:0] mode_reg  [NREGS];
    logic [15:0] mode_next [NREGS];
    logic        en_on;
    logic        caps;
    logic        locked;

    assign en_on = mode_reg[R_ENABLE][EN_ON];
    assign caps  = mode_reg[R_ENABLE][EN_CAPS];

    // Write rules: id read-only, bpp only 32, size and depth locked while on
    always_comb
    begin
        locked   = (idx == R_XRES || idx == R_YRES || idx == R_BPP) && en_on;
        wr_taken = wr_en && (idx != R_ID) && (idx <= R_LAST) &&
                   !(idx == R_BPP && wr_val != BPP_32) && !locked;
        wr_clr   = wr_taken && (idx == R_ENABLE) && !en_on &&
                   wr_val[EN_ON] && !wr_val[EN_NOCLR];
    end

    // Next register contents
    always_comb
    begin
        mode_next = mode_reg;
        if (init.load)
        begin
            for (int i = 0; i < NREGS; i++)
                mode_next[i] = '0;
            mode_next[R_XRES]   = {2'b00, init.width};
            mode_next[R_YRES]   = {2'b00, init.height};
            mode_next[R_BPP]    = BPP_32;
            mode_next[R_ENABLE] = EN_ON_VAL;
            mode_next[R_VWIDTH] = {2'b00, init.width};
        end
        else if (wr_taken)
        begin
            if (idx == R_ENABLE)
                mode_next[R_ENABLE] = wr_val & EN_MASK;
            else
                mode_next[idx] = wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
                mode_reg[i] <= '0;
            mode_reg[R_XRES]   <= {2'b00, INIT_WIDTH_RST};
            mode_reg[R_YRES]   <= {2'b00, INIT_HEIGHT_RST};
            mode_reg[R_BPP]    <= BPP_32;
            mode_reg[R_ENABLE] <= EN_ON_VAL;
            mode_reg[R_VWIDTH] <= {2'b00, INIT_WIDTH_RST};
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Single read port: raw value for merging, visible value for host reads
    assign rd_raw = (idx <= R_LAST) ? mode_reg[idx] : '0;

    always_comb
    begin
        priority if (idx == R_ID)
            rd_vis = ID_CODE;
        else if (idx == R_VMEM)
            rd_vis = VMEM_UNITS;
        else if (idx > R_LAST)
            rd_vis = ALL_ONES;
        else if (caps && (idx == R_XRES || idx == R_YRES))
            rd_vis = MAX_DIM;
        else if (caps && idx == R_BPP)
            rd_vis = BPP_32;
        else
            rd_vis = mode_reg[idx];
    end

    // Fixed taps for the geometry check
    assign view.xres   = mode_reg[R_XRES];
    assign view.yres   = mode_reg[R_YRES];
    assign view.bpp    = mode_reg[R_BPP];
    assign view.enable = mode_reg[R_ENABLE];
    assign view.vwidth = mode_reg[R_VWIDTH];
    assign view.xoff   = mode_reg[R_XOFF];
    assign view.yoff   = mode_reg[R_YOFF];

endmodule

[rtl/dmrf_geom.sv]
module dmrf_geom
    import dmrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  geo_op_t    op,
    input  mode_view_t view,
    input  init_load_t init,
    output geom_t      geom,
    output logic       pre_ok,
    output logic       init_bad
);

    logic [15:0] vw;
    logic [15:0] stride;
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [31:0] prod_reg;
    logic [32:0] off_reg;
    logic [32:0] off_next;
    logic [32:0] room;
    logic        fits;
    logic        init_range_bad;
    geom_t       geom_reg;
    logic        init_bad_reg;

    // Virtual width and stride, plus the checks that need no multiply
    always_comb
    begin
        vw     = (view.vwidth < view.xres) ? view.xres : view.vwidth;
        stride = {vw[13:0], 2'b00};
        pre_ok = view.enable[EN_ON] && (view.bpp == BPP_32) &&
                 (view.xres >= MIN_DIM) && (view.yres >= MIN_DIM) &&
                 (view.xres <= MAX_DIM) && (view.yres <= MAX_DIM) &&
                 (vw <= MAX_DIM);
    end

    // Shared multiplier operand select
    always_comb
    begin
        unique case (op)
            GEO_INIT_MUL:
            begin
                mul_a = {2'b00, init.width};
                mul_b = {2'b00, init.height};
            end
            GEO_PRE:
            begin
                mul_a = view.yoff;
                mul_b = stride;
            end
            default:
            begin
                mul_a = stride;
                mul_b = view.yres;
            end
        endcase
    end

    // Frame fit: start within memory and stride*height fits after start; initial mode size range
    always_comb
    begin
        off_next = {1'b0, prod_reg} + {15'b0, view.xoff, 2'b00};
        room     = VRAM_BYTES - off_reg;
        fits     = (off_reg <= VRAM_BYTES) && ({1'b0, prod_reg} <= room);
        init_range_bad = ({2'b00, init.width} < MIN_DIM) ||
                         ({2'b00, init.width} > MAX_DIM) ||
                         ({2'b00, init.height} < MIN_DIM) ||
                         ({2'b00, init.height} > MAX_DIM);
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (op == GEO_INIT_MUL || op == GEO_PRE || op == GEO_OFFSET)
            prod_reg <= 32'(mul_a) * 32'(mul_b);
        if (op == GEO_OFFSET)
            off_reg <= off_next;
    end

    // Latched geometry and initial mode check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg     <= initial_geom(INIT_WIDTH_RST, INIT_HEIGHT_RST);
            init_bad_reg <= 1'b0;
        end
        else
        begin
            if (init.load)
                geom_reg <= initial_geom(init.width, init.height);
            else if (op == GEO_COMMIT && fits)
            begin
                geom_reg.width  <= view.xres[13:0];
                geom_reg.height <= view.yres[13:0];
                geom_reg.stride <= stride;
                geom_reg.start  <= off_reg[24:0];
            end
            if (op == GEO_INIT_CHK)
                init_bad_reg <= init_range_bad || ({1'b0, prod_reg} > INIT_AREA_MAX);
        end
    end

    assign geom     = geom_reg;
    assign init_bad = init_bad_reg;

endmodule

[rtl/display_mode_register_file.sv]
// Each request first runs the initial mode check (INIT_MUL, INIT_CHK); a rejected request
// then goes to DONE, a read gathers its bytes in READ and a write merges each touched
// register in WMERGE. A request is taken only when idle, once the last result is registered.
// The single shared 16x16 multiplier runs the initial mode check and the scanout geometry
// check, one register write after another.
// Reset (rst_n, async low): initial mode 1024x768, registers and geometry loaded.
module display_mode_register_file
    import dmrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [13:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  dmrf_req_t   in_req,
    output logic        out_valid,
    input  logic        out_stall,
    output dmrf_rsp_t   out_rsp
);

    ctrl_state_t state_reg, state_next;
    logic [13:0] init_w_reg, init_h_reg;
    dmrf_req_t   req_reg;
    logic        ok_reg, ok_next;
    logic [1:0]  b_reg, b_next;
    logic [3:0]  r_reg, r_next;
    logic [31:0] rd_acc_reg, rd_acc_next;
    logic        clr_reg, clr_next;
    logic        out_valid_reg, out_valid_next;
    dmrf_rsp_t   out_rsp_reg, out_rsp_next;

    init_load_t  init;
    geo_op_t     geo_op;
    geom_t       geom;
    mode_view_t  view;
    logic        pre_ok;
    logic        init_bad;
    logic        rf_wr_en;
    logic [3:0]  rf_idx;
    logic [15:0] rf_raw, rf_vis;
    logic        rf_taken, rf_clr;

    logic        size_ok, range_ok;
    logic [12:0] a_end;
    logic [11:0] a_lo, a_hi, lo_rel, hi_rel;
    logic        touches;
    logic [3:0]  r_first, r_last;
    logic [1:0]  cnt_last;
    logic [11:0] rd_addr, rd_rel;
    logic        rd_in_win;
    logic [7:0]  rd_byte;
    logic [11:0] reg_lo, reg_hi;
    logic        hit_lo, hit_hi;
    logic [1:0]  lane_lo, lane_hi;
    logic [15:0] upd;

    // Initial mode registers; a write reloads the mode registers and the scanout geometry
    always_comb
    begin
        init.load   = cfg_wr_en;
        init.width  = (cfg_wr_en && cfg_index == CFG_INIT_WIDTH)  ? cfg_data : init_w_reg;
        init.height = (cfg_wr_en && cfg_index == CFG_INIT_HEIGHT) ? cfg_data : init_h_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_w_reg <= INIT_WIDTH_RST;
            init_h_reg <= INIT_HEIGHT_RST;
        end
        else
        begin
            init_w_reg <= init.width;
            init_h_reg <= init.height;
        end
    end

    dmrf_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .init     (init),
        .wr_en    (rf_wr_en),
        .wr_val   (upd),
        .idx      (rf_idx),
        .rd_raw   (rf_raw),
        .rd_vis   (rf_vis),
        .wr_taken (rf_taken),
        .wr_clr   (rf_clr),
        .view     (view)
    );

    dmrf_geom u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (geo_op),
        .view     (view),
        .init     (init),
        .geom     (geom),
        .pre_ok   (pre_ok),
        .init_bad (init_bad)
    );

    // Request decode
    always_comb
    begin
        size_ok  = (in_req.byte_count == 4'd1) || (in_req.byte_count == 4'd2) ||
                   (in_req.byte_count == 4'd4);
        range_ok = ({1'b0, in_req.byte_offset} + {9'b0, in_req.byte_count}) <= MMIO_BYTES;

        a_lo     = req_reg.byte_offset;
        a_end    = {1'b0, a_lo} + {9'b0, req_reg.byte_count};
        a_hi     = 12'(a_end - 13'd1);
        cnt_last = 2'(req_reg.byte_count - 4'd1);
        touches  = (a_hi >= WIN_BASE) && (a_lo < WR_END);
        lo_rel   = a_lo - WIN_BASE;
        hi_rel   = a_hi - WIN_BASE;
        r_first  = (a_lo < WIN_BASE) ? R_ID : lo_rel[4:1];
        r_last   = (a_hi >= WR_END) ? R_LAST : hi_rel[4:1];
    end

    // Read byte lane
    always_comb
    begin
        rd_addr   = a_lo + {10'b0, b_reg};
        rd_rel    = rd_addr - WIN_BASE;
        rd_in_win = (rd_addr >= WIN_BASE) && (rd_addr < RD_END);
        if (!rd_in_win)
            rd_byte = 8'hff;
        else if (rd_addr[0])
            rd_byte = rf_vis[15:8];
        else
            rd_byte = rf_vis[7:0];
    end

    // Byte merge for the register under r_reg
    always_comb
    begin
        reg_lo  = WIN_BASE + {7'b0, r_reg, 1'b0};
        reg_hi  = {reg_lo[11:1], 1'b1};
        hit_lo  = (reg_lo >= a_lo) && (reg_lo <= a_hi);
        hit_hi  = (reg_hi >= a_lo) && (reg_hi <= a_hi);
        lane_lo = 2'(reg_lo - a_lo);
        lane_hi = 2'(reg_hi - a_lo);
        upd     = rf_raw;
        if (hit_lo)
            upd[7:0] = req_reg.write_data[{lane_lo, 3'b000} +: 8];
        if (hit_hi)
            upd[15:8] = req_reg.write_data[{lane_hi, 3'b000} +: 8];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ok_next        = ok_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        rd_acc_next    = rd_acc_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_rsp_next   = out_rsp_reg;
        geo_op         = GEO_IDLE;
        rf_wr_en       = 1'b0;
        rf_idx         = r_reg;
        in_stall       = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ok_next    = size_ok && range_ok;
                    state_next = ST_INIT_MUL;
                end
            end
            ST_INIT_MUL:
            begin
                geo_op     = GEO_INIT_MUL;
                state_next = ST_INIT_CHK;
            end
            ST_INIT_CHK:
            begin
                geo_op      = GEO_INIT_CHK;
                rd_acc_next = '0;
                clr_next    = 1'b0;
                b_next      = '0;
                r_next      = r_first;
                if (!ok_reg)
                    state_next = ST_DONE;
                else if (req_reg.command == CMD_READ)
                    state_next = ST_READ;
                else if (touches)
                    state_next = ST_WMERGE;
                else
                    state_next = ST_DONE;
            end
            ST_READ:
            begin
                rf_idx = rd_rel[4:1];
                rd_acc_next[{b_reg, 3'b000} +: 8] = rd_byte;
                if (b_reg == cnt_last)
                    state_next = ST_DONE;
                else
                    b_next = b_reg + 2'd1;
            end
            ST_WMERGE:
            begin
                rf_wr_en = 1'b1;
                clr_next = clr_reg | rf_clr;
                if (rf_taken)
                    state_next = ST_VPRE;
                else if (r_reg == r_last)
                    state_next = ST_DONE;
                else
                    r_next = r_reg + 4'd1;
            end
            ST_VPRE:
            begin
                if (pre_ok)
                begin
                    geo_op     = GEO_PRE;
                    state_next = ST_VOFF;
                end
                else if (r_reg == r_last)
                    state_next = ST_DONE;
                else
                begin
                    r_next     = r_reg + 4'd1;
                    state_next = ST_WMERGE;
                end
            end
            ST_VOFF:
            begin
                geo_op     = GEO_OFFSET;
                state_next = ST_VCOMMIT;
            end
            ST_VCOMMIT:
            begin
                geo_op = GEO_COMMIT;
                if (r_reg == r_last)
                    state_next = ST_DONE;
                else
                begin
                    r_next     = r_reg + 4'd1;
                    state_next = ST_WMERGE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_rsp_next.read_data   = rd_acc_reg;
                    out_rsp_next.access_ok   = ok_reg;
                    out_rsp_next.scan_width  = geom.width;
                    out_rsp_next.scan_height = geom.height;
                    out_rsp_next.scan_stride = geom.stride;
                    out_rsp_next.scan_start  = geom.start;
                    out_rsp_next.clear_vram  = clr_reg;
                    out_rsp_next.mode_error  = init_bad;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            b_reg         <= '0;
            r_reg         <= '0;
            clr_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
            b_reg         <= b_next;
            r_reg         <= r_next;
            clr_reg       <= clr_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
            req_reg <= in_req;
        rd_acc_reg  <= rd_acc_next;
        out_rsp_reg <= out_rsp_next;
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    // One request at a time: the port closes right after a request is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while sequencer busy");

    // A result only comes out of the final sequencer state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_DONE))
        else $error("result produced outside final state");

    // A rejected request returns no data and never asks for a clear
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_rsp.access_ok) |-> (out_rsp.read_data == '0 && !out_rsp.clear_vram))
        else $error("rejected request returned data or clear");

    // Geometry writes happen only after a register write was taken
    a_commit_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VCOMMIT) |-> ($past(state_reg, 2) == ST_VPRE && $past(pre_ok, 2)))
        else $error("geometry commit without checked register write");

endmodule
